FILE: src/bbc_bitmap_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// BBC decoder assertion macros
// Shared concurrent assertion forms used by the queue and back end modules.
// ----------------------------------------------------------------------------
`ifndef BBC_BITMAP_DECODER_CORE_ASSERT_SVH
`define BBC_BITMAP_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BBCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bbcd_pkg.sv
// ----------------------------------------------------------------------------
// BBC decoder package
// Result kinds, command word passed from front end to back end, and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcd_pkg;

    // Result kinds as seen on the output port
    typedef enum logic [1:0] {
        KIND_RUN = 2'd0,
        KIND_LIT = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    localparam int RUN_LEN_W   = 33;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FILL_ONES  = 8'hFF;
    localparam logic [7:0] FILL_ZEROS = 8'h00;

    // One decoded byte: an optional run result followed by an optional literal
    typedef struct packed {
        logic                 has_run;
        kind_t                run_kind;
        logic [7:0]           run_value;
        logic [RUN_LEN_W-1:0] run_len;
        logic                 has_lit;
        logic [7:0]           lit_value;
    } cmd_t;

    function automatic logic [7:0] fill_byte(input logic f);
        fill_byte = f ? FILL_ONES : FILL_ZEROS;
    endfunction

    // Single set bit at pos, inverted for a ones fill
    function automatic logic [7:0] odd_byte(input logic f, input logic [2:0] pos);
        logic [7:0] v;
        v = 8'd1 << pos;
        odd_byte = f ? ~v : v;
    endfunction

endpackage

`default_nettype wire

FILE: src/bbcd_front.sv
// ----------------------------------------------------------------------------
// BBC decoder front end
// Parses header, counter and tail bytes and pushes at most one command per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcd_front
    import bbcd_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] code_byte,
    input  wire logic       restart,
    output logic            push,
    output cmd_t            cmd
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNTER = 2'd1,
        PH_TAIL    = 2'd2
    } phase_t;

    localparam int LW = (COUNTER_WIDTH > RUN_LEN_W) ? COUNTER_WIDTH : RUN_LEN_W;

    phase_t                   phase_reg, phase_next, phase_cur;
    logic                     fill_reg, fill_next, fill_cur;
    logic                     odd_kind_reg, odd_kind_next, odd_kind_cur;
    logic [3:0]               tail_reg, tail_next, tail_cur;
    logic [2:0]               pos_reg, pos_next, pos_cur;
    logic [COUNTER_WIDTH-1:0] acc_reg, acc_next, acc_cur, acc_shift;
    logic                     ovf_reg, ovf_next, ovf_cur, ovf_shift;
    logic [LW-1:0]            acc_wide;
    logic [RUN_LEN_W-1:0]     counted_len;
    logic [3:0]               tail_dec;

    // Restart clears state before the byte is decoded
    always_comb
    begin
        if (restart)
        begin
            phase_cur    = PH_HEADER;
            fill_cur     = 1'b0;
            odd_kind_cur = 1'b0;
            tail_cur     = '0;
            pos_cur      = '0;
            acc_cur      = '0;
            ovf_cur      = 1'b0;
        end
        else
        begin
            phase_cur    = phase_reg;
            fill_cur     = fill_reg;
            odd_kind_cur = odd_kind_reg;
            tail_cur     = tail_reg;
            pos_cur      = pos_reg;
            acc_cur      = acc_reg;
            ovf_cur      = ovf_reg;
        end
    end

    // Counter group shift-in and fill length (counter + 4)
    assign ovf_shift   = ovf_cur | (|acc_cur[COUNTER_WIDTH-1 -: 7]);
    assign acc_shift   = {acc_cur[COUNTER_WIDTH-8:0], code_byte[6:0]};
    assign acc_wide    = LW'(acc_shift);
    assign counted_len = acc_wide[RUN_LEN_W-1:0] + RUN_LEN_W'(4);
    assign tail_dec    = tail_cur - 4'd1;

    // Byte decode
    always_comb
    begin
        phase_next    = phase_cur;
        fill_next     = fill_cur;
        odd_kind_next = odd_kind_cur;
        tail_next     = tail_cur;
        pos_next      = pos_cur;
        acc_next      = acc_cur;
        ovf_next      = ovf_cur;
        cmd           = '0;
        cmd.run_kind  = KIND_RUN;

        case (phase_cur)
            PH_COUNTER:
            begin
                acc_next = acc_shift;
                ovf_next = ovf_shift;
                if (!code_byte[7])
                begin
                    cmd.has_run = 1'b1;
                    if (ovf_shift)
                    begin
                        cmd.run_kind  = KIND_ERR;
                        cmd.run_value = '0;
                        cmd.run_len   = '0;
                    end
                    else
                    begin
                        cmd.run_kind  = KIND_RUN;
                        cmd.run_value = fill_byte(fill_cur);
                        cmd.run_len   = counted_len;
                    end
                    phase_next = PH_HEADER;
                    if (odd_kind_cur)
                    begin
                        cmd.has_lit   = 1'b1;
                        cmd.lit_value = odd_byte(fill_cur, pos_cur);
                    end
                    else if (tail_cur != 4'd0)
                    begin
                        phase_next = PH_TAIL;
                    end
                end
            end
            PH_TAIL:
            begin
                cmd.has_lit   = 1'b1;
                cmd.lit_value = code_byte;
                tail_next     = tail_dec;
                if (tail_dec == 4'd0)
                    phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_HEADER;
                if (code_byte[7])
                begin
                    // short fill with literal tail
                    fill_next     = code_byte[6];
                    cmd.has_run   = (code_byte[5:4] != 2'd0);
                    cmd.run_value = fill_byte(code_byte[6]);
                    cmd.run_len   = RUN_LEN_W'(code_byte[5:4]);
                    tail_next     = code_byte[3:0];
                    if (code_byte[3:0] != 4'd0)
                        phase_next = PH_TAIL;
                end
                else if (code_byte[6])
                begin
                    // short fill with odd bit
                    fill_next     = code_byte[5];
                    pos_next      = code_byte[2:0];
                    cmd.has_run   = (code_byte[4:3] != 2'd0);
                    cmd.run_value = fill_byte(code_byte[5]);
                    cmd.run_len   = RUN_LEN_W'(code_byte[4:3]);
                    cmd.has_lit   = 1'b1;
                    cmd.lit_value = odd_byte(code_byte[5], code_byte[2:0]);
                end
                else if (code_byte[5])
                begin
                    // counted fill with tail
                    fill_next     = code_byte[4];
                    odd_kind_next = 1'b0;
                    tail_next     = code_byte[3:0];
                    acc_next      = '0;
                    ovf_next      = 1'b0;
                    phase_next    = PH_COUNTER;
                end
                else
                begin
                    // counted fill with odd bit
                    fill_next     = code_byte[3];
                    odd_kind_next = 1'b1;
                    pos_next      = code_byte[2:0];
                    acc_next      = '0;
                    ovf_next      = 1'b0;
                    phase_next    = PH_COUNTER;
                end
            end
        endcase
    end

    assign push = accept && (cmd.has_run || cmd.has_lit);

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            fill_reg     <= 1'b0;
            odd_kind_reg <= 1'b0;
            tail_reg     <= '0;
            pos_reg      <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            odd_kind_reg <= odd_kind_next;
            tail_reg     <= tail_next;
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/bbcd_queue.sv
// ----------------------------------------------------------------------------
// BBC decoder command queue
// Short FIFO of decoded commands between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bbc_bitmap_decoder_core_assert.svh"

module bbcd_queue
    import bbcd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign empty = (count_reg == QUEUE_CW'(0));
    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + QUEUE_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - QUEUE_CW'(1);
        end
    end

    `BBCD_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
    `BBCD_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
    `BBCD_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + QUEUE_CW'(1), "count did not advance on push")

endmodule

`default_nettype wire

FILE: src/bbcd_back.sv
// ----------------------------------------------------------------------------
// BBC decoder back end
// Expands each command into its run and literal results on the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bbc_bitmap_decoder_core_assert.svh"

module bbcd_back
    import bbcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  head,
    input  wire logic                  q_empty,
    output logic                       pop,
    input  wire logic                  result_stall,
    output logic                       result_valid,
    output logic [1:0]                 kind,
    output logic [7:0]                 value,
    output logic [RUN_LEN_W-1:0]       run_length,
    output logic                       last
);

    logic                 valid_reg;
    logic                 run_done_reg, run_done_next;
    logic [1:0]           kind_reg, kind_next;
    logic [7:0]           value_reg, value_next;
    logic [RUN_LEN_W-1:0] len_reg, len_next;
    logic                 last_reg, last_next;
    logic                 load, take, emit_run;

    // Output register may load when empty or being drained
    assign load     = !valid_reg || !result_stall;
    assign take     = load && !q_empty;
    assign emit_run = head.has_run && !run_done_reg;
    assign pop      = take && (!emit_run || !head.has_lit);

    // Select next result from the head command
    always_comb
    begin
        run_done_next = run_done_reg;
        kind_next     = kind_reg;
        value_next    = value_reg;
        len_next      = len_reg;
        last_next     = last_reg;
        if (take)
        begin
            if (emit_run)
            begin
                kind_next     = head.run_kind;
                value_next    = head.run_value;
                len_next      = head.run_len;
                last_next     = !head.has_lit;
                run_done_next = head.has_lit;
            end
            else
            begin
                kind_next     = KIND_LIT;
                value_next    = head.lit_value;
                len_next      = RUN_LEN_W'(1);
                last_next     = 1'b1;
                run_done_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            run_done_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg    <= take;
            run_done_reg <= run_done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            len_reg   <= len_next;
            last_reg  <= last_next;
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign run_length   = len_reg;
    assign last         = last_reg;

    `BBCD_ASSERT_NOW(a_err_zero, clk, rst_n, valid_reg && kind_reg == KIND_ERR,
        value_reg == 8'd0 && len_reg == '0, "error result carries data")
    `BBCD_ASSERT_NOW(a_lit_len, clk, rst_n, valid_reg && kind_reg == KIND_LIT,
        len_reg == RUN_LEN_W'(1) && last_reg, "literal result malformed")
    `BBCD_ASSERT_NOW(a_split_head, clk, rst_n, run_done_reg,
        !q_empty && valid_reg && !last_reg, "split command lost its head")

endmodule

`default_nettype wire

FILE: src/bbc_bitmap_decoder_core.sv
// ----------------------------------------------------------------------------
// BBC bitmap decoder core
// Decodes a byte-aligned bitmap code stream into fill runs and literal bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Code channel: code_valid / code_stall with code_byte and restart. One
//   compressed byte per transaction; restart=1 clears decoder state first
//   and the byte is then decoded as a header.
//   Result channel: result_valid / result_stall with kind, value, run_length
//   and last. Each byte yields zero, one or two results; last marks the final
//   one for that byte. Header and counter bytes that only update state give
//   no result.
//   Path: decode is combinational and writes the command queue at the
//   accepting edge; the output register then loads from the queue.
//   Throughput: one code byte per cycle while code_stall is low; the output
//   register emits one result per cycle while result_stall is low, so a
//   byte that yields both a run and a literal holds it for two results.
//   A four-entry command queue absorbs these bursts.
//   When the receiver stalls, the result holds steady and the queue fills;
//   code_stall rises once the queue is full.
//   Reset clears the decoder state, empties the queue and clears result_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_bitmap_decoder_core
    import bbcd_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  code_valid,
    output logic                       code_stall,
    input  wire logic [7:0]            code_byte,
    input  wire logic                  restart,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [1:0]                 kind,
    output logic [7:0]                 value,
    output logic [RUN_LEN_W-1:0]       run_length,
    output logic                       last
);

    logic accept, push, pop, q_empty, q_full;
    cmd_t cmd, head;

    assign code_stall = q_full;
    assign accept     = code_valid && !q_full;

    // Byte decode
    bbcd_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_byte (code_byte),
        .restart   (restart),
        .push      (push),
        .cmd       (cmd)
    );

    // Command queue
    bbcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Result expansion
    bbcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .kind         (kind),
        .value        (value),
        .run_length   (run_length),
        .last         (last)
    );

endmodule

`default_nettype wire
